### rtl/hba_pkg.sv
// Package for the hierarchical bitmap allocator: default sizes, field widths,
// status and command codes, sequencer states, and the capacity function.
// No dependencies.
package hba_pkg;

  // Default sizing of the bitmap hierarchy
  localparam int DEF_FANOUT = 32;
  localparam int DEF_LEVELS = 2;

  // Index space reach of the 10-bit index field
  localparam int INDEX_W    = 10;
  localparam int INDEX_SPAN = 1 << INDEX_W;

  // Stream payload widths (tdata fields padded to whole bytes)
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 16;
  localparam int STATUS_W    = 2;

  // Fixed-point shift for the divide-by-fanout reciprocal
  localparam int DIV_SHIFT = 20;

  // Request kinds carried in tuser
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes carried in tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Request sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_MOD,
    S_DONE
  } state_t;

  // Number of usable indices: fanout to the power levels, capped at the span
  function automatic int calc_capacity(int fanout, int levels);
    int c;
    c = 1;
    for (int i = 0; i < levels; i++) begin
      if (c < INDEX_SPAN) begin
        c = c * fanout;
      end
    end
    if (c > INDEX_SPAN) begin
      c = INDEX_SPAN;
    end
    return c;
  endfunction

endpackage

### rtl/hierarchical_bitmap_allocator.sv
// Hierarchical bitmap allocator: the request sequencer, the leaf word memory,
// the group full flags and the shared find-lowest-set-bit unit.
// Depends on hba_pkg.
//
// Each request (allocate the lowest free index, or free a given index) passes
// through the sequencer states in order: acceptance in S_IDLE, S_LOOK, in
// which the shared find-lowest-set-bit unit picks the first group not marked
// full (or the group of the freed index is formed by reciprocal multiply) and
// the leaf word is read, S_MOD, in which the same unit finds the lowest clear
// bit of that word and the word is written back, and S_DONE, which holds the
// result until the output transfer. The single read-modify-write of the leaf
// memory bounds the rate; the block takes one request at a time.
// Leaf words carry one valid flag each, cleared at reset, so no clearing pass
// is needed and requests are taken right after reset.
module hierarchical_bitmap_allocator #(
  parameter int FANOUT = hba_pkg::DEF_FANOUT,
  parameter int LEVELS = hba_pkg::DEF_LEVELS
) (
  input  logic                             clk,
  input  logic                             rst,
  // Request channel
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [hba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [9:0] index, rest zero
  input  logic [hba_pkg::IN_TUSER_W-1:0]   s_axis_tuser,   // [0] command
  // Result channel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [hba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [9:0] result_index, rest zero
  output logic [hba_pkg::STATUS_W-1:0]     m_axis_tuser    // [1:0] status
);
  import hba_pkg::*;

  localparam int CAP       = calc_capacity(FANOUT, LEVELS);
  localparam int GROUPS    = (CAP + FANOUT - 1) / FANOUT;
  localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int BIT_W     = $clog2(FANOUT);
  localparam int SCAN_W    = (GROUPS > FANOUT) ? GROUPS : FANOUT;
  localparam int SCAN_IW   = $clog2(SCAN_W);
  localparam int LAST_BITS = CAP - (GROUPS - 1) * FANOUT;
  localparam int RECIP     = ((1 << DIV_SHIFT) + FANOUT - 1) / FANOUT;
  localparam int RECIP_W   = $clog2(RECIP + 1);
  localparam int PROD_W    = INDEX_W + RECIP_W;

  localparam logic [FANOUT-1:0]  LAST_MASK = {FANOUT{1'b1}} >> (FANOUT - LAST_BITS);
  localparam logic [INDEX_W:0]   CAP_V     = (INDEX_W + 1)'(CAP);
  localparam logic [GRP_W-1:0]   LAST_GRP  = GRP_W'(GROUPS - 1);
  localparam logic [RECIP_W-1:0] RECIP_V   = RECIP_W'(RECIP);

  state_t state, state_next;

  // Request and lookup registers
  logic               cmd;
  logic [INDEX_W-1:0] idx;
  logic [GRP_W-1:0]   grp;
  logic               miss;
  logic               err;
  logic [FANOUT-1:0]  rdata;
  logic               rd_valid;
  status_t            status_r;
  logic [INDEX_W-1:0] result_r;

  // Per-group control state
  logic [GROUPS-1:0]  group_full;
  logic [GROUPS-1:0]  leaf_valid;

  // Leaf word memory
  logic [FANOUT-1:0]  leaf_mem [GROUPS];

  // Shared find-lowest-set-bit unit
  logic [SCAN_W-1:0]  scan_vec;
  logic [SCAN_IW-1:0] scan_idx;
  logic               scan_hit;

  // Lookup cycle signals
  logic [PROD_W-1:0]  prod;
  logic               range_err;
  logic [GRP_W-1:0]   look_grp;

  // Modify cycle signals
  logic [FANOUT-1:0]  word;
  logic [FANOUT-1:0]  vmask;
  logic [FANOUT-1:0]  free_bits;
  logic [FANOUT-1:0]  alloc_word;
  logic [FANOUT-1:0]  freed_word;
  logic [INDEX_W-1:0] grp_base;
  logic [INDEX_W-1:0] offset;
  logic [BIT_W-1:0]   bit_sel;
  logic               mem_we;
  logic [FANOUT-1:0]  mem_wdata;
  logic               set_full;
  logic               clr_full;
  status_t            res_status;
  logic [INDEX_W-1:0] res_index;

  // Scan operand: free groups during lookup, free leaf bits during modify
  always_comb begin
    scan_vec = '0;
    if (state == S_LOOK) begin
      scan_vec[GROUPS-1:0] = ~group_full;
    end else begin
      scan_vec[FANOUT-1:0] = free_bits;
    end
  end

  // Lowest set bit of the scan operand
  always_comb begin
    scan_hit = 1'b0;
    scan_idx = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (scan_vec[i]) begin
        scan_hit = 1'b1;
        scan_idx = SCAN_IW'(i);
      end
    end
  end

  // Lookup: group of a freed index by reciprocal multiply, or first free group
  always_comb begin
    prod      = PROD_W'(idx) * PROD_W'(RECIP_V);
    range_err = {1'b0, idx} >= CAP_V;
    if (cmd == CMD_FREE) begin
      look_grp = range_err ? '0 : prod[DIV_SHIFT +: GRP_W];
    end else begin
      look_grp = scan_idx[GRP_W-1:0];
    end
  end

  // Modify: word update and result forming
  always_comb begin
    word       = rd_valid ? rdata : '0;
    vmask      = (grp == LAST_GRP) ? LAST_MASK : '1;
    free_bits  = ~word & vmask;
    grp_base   = INDEX_W'(int'(grp) * FANOUT);
    offset     = idx - grp_base;
    bit_sel    = scan_idx[BIT_W-1:0];
    alloc_word = word | (FANOUT'(1) << bit_sel);
    freed_word = word & ~(FANOUT'(1) << offset[BIT_W-1:0]);
    mem_we     = 1'b0;
    mem_wdata  = alloc_word;
    set_full   = 1'b0;
    clr_full   = 1'b0;
    res_status = ST_OK;
    res_index  = '0;
    if (state == S_MOD) begin
      if (cmd == CMD_ALLOC) begin
        if (miss) begin
          res_status = ST_FULL;
        end else if (free_bits == '0) begin
          // stale flag: mark the group full and report no space
          set_full   = 1'b1;
          res_status = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          set_full  = (alloc_word & vmask) == vmask;
          res_index = grp_base + INDEX_W'(bit_sel);
        end
      end else begin
        if (err) begin
          res_status = ST_RANGE;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = freed_word;
          clr_full  = 1'b1;
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: state_next = S_MOD;
      S_MOD:  state_next = S_DONE;
      S_DONE: begin
        if (m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    m_axis_tvalid = (state == S_DONE);
  end

  assign m_axis_tdata = {(OUT_TDATA_W - INDEX_W)'(0), result_r};
  assign m_axis_tuser = status_r;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Group flags and leaf valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      group_full <= '0;
      leaf_valid <= '0;
    end else begin
      if (set_full) begin
        group_full[grp] <= 1'b1;
      end else if (clr_full) begin
        group_full[grp] <= 1'b0;
      end
      if (mem_we) begin
        leaf_valid[grp] <= 1'b1;
      end
    end
  end

  // Leaf memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      leaf_mem[grp] <= mem_wdata;
    end
    if (state == S_LOOK) begin
      rdata <= leaf_mem[look_grp];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd <= s_axis_tuser[0];
      idx <= s_axis_tdata[INDEX_W-1:0];
    end
    if (state == S_LOOK) begin
      grp      <= look_grp;
      miss     <= (cmd == CMD_ALLOC) && !scan_hit;
      err      <= (cmd == CMD_FREE) && range_err;
      rd_valid <= leaf_valid[look_grp];
    end
    if (state == S_MOD) begin
      status_r <= res_status;
      result_r <= res_index;
    end
  end

  // Checks
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == S_LOOK)
    else $error("accepted request did not start a lookup");

  a_fail_zero_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && status_r != ST_OK |-> result_r == '0)
    else $error("failed request returned a nonzero index");

  a_alloc_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> {1'b0, result_r} < CAP_V)
    else $error("result index beyond capacity");

  a_alloc_marks_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && cmd == CMD_ALLOC && status_r == ST_OK |-> leaf_valid[grp])
    else $error("successful allocate left its leaf word unwritten");

  a_range_only_free: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && status_r == ST_RANGE |-> cmd == CMD_FREE)
    else $error("range error reported for an allocate");

endmodule
